>>> rtl/mmq_pkg.sv
// mmq_pkg: shared constants and types for the matching message queue
package mmq_pkg;

  // default sizing
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // fixed field widths of the channels
  localparam int ID_W      = 8;
  localparam int PAY_FLD_W = 32;
  localparam int FILL_W    = 5;
  localparam int STATUS_W  = 2;

  typedef logic [STATUS_W-1:0] status_t;

  // request kinds
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  // result status codes
  localparam status_t ST_STORED   = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_TAKEN    = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

endpackage

>>> rtl/mmq_if.sv
// mmq_req_if and mmq_rsp_if: request and result channels of the message queue
interface mmq_req_if import mmq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [ID_W-1:0]      source_id;
  logic [ID_W-1:0]      dest_id;
  logic                 match_any_source;
  logic [PAY_FLD_W-1:0] payload;

  modport source (output valid, req_type, source_id, dest_id, match_any_source, payload,
                  input ready);
  modport sink (input valid, req_type, source_id, dest_id, match_any_source, payload,
                output ready);
endinterface

interface mmq_rsp_if import mmq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [ID_W-1:0]      out_source;
  logic [ID_W-1:0]      out_dest;
  logic [PAY_FLD_W-1:0] out_payload;
  logic [FILL_W-1:0]    fill_level;

  modport source (output valid, status, out_source, out_dest, out_payload, fill_level,
                  input ready);
  modport sink (input valid, status, out_source, out_dest, out_payload, fill_level,
                output ready);
endinterface

>>> rtl/matching_message_queue.sv
// matching_message_queue: ordered message store with matched take
//
// Requests arrive on req (valid/ready); each request gives exactly one
// item on rsp (valid/ready). A put appends source, destination and payload
// at the tail or reports full. A take returns and removes the oldest entry
// whose destination matches, and whose source matches unless
// match_any_source is set; later entries move up one place.
// One request is handled at a time: req.ready is high only while idle.
// A put and a take on an empty store go straight to the result; any other
// take first scans the held entries from the oldest, reading and then
// comparing each in turn, and on a hit compacts the later entries, reading
// and rewriting each one place up. The single memory read port serves
// both, and the two together touch every held entry once.
// The result stays on rsp until rsp.ready; no new request is taken until
// then. Reset empties the store at once (the count clears; the stored
// entries are not cleared and are never read before being written).
module matching_message_queue import mmq_pkg::*; #(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int EW = 2 * ID_W + PAYLOAD_WIDTH
) (
  input logic       clk,
  input logic       rst,
  mmq_req_if.sink   req,
  mmq_rsp_if.source rsp
);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  // sequencer with the shared compare
  mmq_ctrl #(
    .DEPTH(QUEUE_DEPTH),
    .PW   (PAYLOAD_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // entry memory
  mmq_store #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(EW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

`ifndef SYNTHESIS
  // one request in flight: never ready for a new one while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request accepted while a result is pending");

  // an accepted request blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("input still ready after accepting an item");

  // a full rejection only happens with the store at capacity
  a_full_level: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (rsp.fill_level == FILL_W'(QUEUE_DEPTH)))
    else $error("full status with store below capacity");

  // only a taken message carries message fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_TAKEN) |->
      (rsp.out_source == '0 && rsp.out_dest == '0 && rsp.out_payload == '0))
    else $error("message fields set without a taken message");
`endif

endmodule

>>> rtl/mmq_store.sv
// mmq_store: entry memory, one write and one registered read port
module mmq_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mmq_ctrl.sv
// mmq_ctrl: sequencer that scans, matches and compacts the entry store
module mmq_ctrl import mmq_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int PW    = PAYLOAD_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int EW = 2 * ID_W + PW
) (
  input  logic          clk,
  input  logic          rst,
  mmq_req_if.sink       req,
  mmq_rsp_if.source     rsp,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [EW-1:0] mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [EW-1:0] mem_rdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;

  logic [2:0]           state;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic [ID_W-1:0]      sid;
  logic [ID_W-1:0]      did;
  logic                 any_src;
  status_t              status;
  logic [ID_W-1:0]      osrc;
  logic [ID_W-1:0]      odst;
  logic [PAY_FLD_W-1:0] opay;

  logic          accept;
  logic          full;
  logic          hit;
  logic [CW-1:0] idx_inc;
  logic [ID_W-1:0] rd_src;
  logic [ID_W-1:0] rd_dst;
  logic [PW-1:0]   rd_body;
  logic [63:0]     pay_wide;
  logic [63:0]     body_wide;
  logic [PW-1:0]   body_in;
  logic [CW+FILL_W-1:0] count_wide;

  assign accept  = req.valid && req.ready;
  assign full    = (count == CW'(DEPTH));
  assign idx_inc = idx + 1'b1;

  // split the stored entry and run the shared compare
  assign {rd_src, rd_dst, rd_body} = mem_rdata;
  assign hit = (rd_dst == did) && (any_src || (rd_src == sid));

  // payload width conversion in both directions
  assign pay_wide  = 64'(req.payload);
  assign body_in   = pay_wide[PW-1:0];
  assign body_wide = 64'(rd_body);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = {req.source_id, req.dest_id, body_in};
    mem_raddr = idx[AW-1:0];
    case (state)
      S_IDLE:     mem_we = accept && (req.req_type == REQ_PUT) && !full;
      S_SHIFT_RD: mem_raddr = idx_inc[AW-1:0];
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.req_type == REQ_PUT) begin
              if (!full) begin
                count <= count + 1'b1;
              end
              state <= S_RESP;
            end else if (count == '0) begin
              state <= S_RESP;
            end else begin
              idx   <= '0;
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (hit) begin
            if (idx_inc == count) begin
              count <= count - 1'b1;
              state <= S_RESP;
            end else begin
              state <= S_SHIFT_RD;
            end
          end else if (idx_inc == count) begin
            state <= S_RESP;
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          if ((idx_inc + 1'b1) == count) begin
            count <= count - 1'b1;
            state <= S_RESP;
          end else begin
            idx   <= idx_inc;
            state <= S_SHIFT_RD;
          end
        end
        S_RESP: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      sid     <= req.source_id;
      did     <= req.dest_id;
      any_src <= req.match_any_source;
      osrc    <= '0;
      odst    <= '0;
      opay    <= '0;
      if (req.req_type == REQ_PUT) begin
        status <= full ? ST_FULL : ST_STORED;
      end else begin
        status <= ST_NOTFOUND;
      end
    end else if (state == S_SCAN_CMP && hit) begin
      status <= ST_TAKEN;
      osrc   <= rd_src;
      odst   <= rd_dst;
      opay   <= body_wide[PAY_FLD_W-1:0];
    end
  end

  // channel outputs
  assign count_wide      = (CW + FILL_W)'(count);
  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_RESP);
  assign rsp.status      = status;
  assign rsp.out_source  = osrc;
  assign rsp.out_dest    = odst;
  assign rsp.out_payload = opay;
  assign rsp.fill_level  = count_wide[FILL_W-1:0];

endmodule

>>> sim/mmq_checker.sv
// mmq_checker: predicts each result of the message queue and compares it with what comes out
module mmq_checker import mmq_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  mmq_req_if   req,
  mmq_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic [ID_W-1:0]      src;
    logic [ID_W-1:0]      dst;
    logic [PAY_FLD_W-1:0] body;
  } held_msg_t;

  typedef struct {
    status_t              status;
    logic [ID_W-1:0]      src;
    logic [ID_W-1:0]      dst;
    logic [PAY_FLD_W-1:0] body;
    logic [FILL_W-1:0]    fill;
  } rsp_item_t;

  // messages the block should hold, oldest first
  held_msg_t held_msgs[$];
  // results owed by the block, oldest first
  rsp_item_t owed_results[$];
  int        printed;

  assign pending = owed_results.size();

  initial begin
    fail_count = 0;
    printed    = 0;
  end

  task automatic report_mismatch(input string msg);
    // cap the log, keep counting
    if (printed < 200) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
      printed++;
    end
    fail_count++;
  endtask

  // apply one request to the mirrored store and return the result it causes
  function automatic rsp_item_t apply_request(input logic kind, input logic [ID_W-1:0] sid,
                                              input logic [ID_W-1:0] did, input logic any,
                                              input logic [PAY_FLD_W-1:0] body);
    rsp_item_t r;
    held_msg_t m;
    int        hit;
    r.status = ST_NOTFOUND;
    r.src    = '0;
    r.dst    = '0;
    r.body   = '0;
    hit      = -1;
    if (kind == REQ_PUT) begin
      if (held_msgs.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        m.src  = sid;
        m.dst  = did;
        m.body = body;
        held_msgs.push_back(m);
        r.status = ST_STORED;
      end
    end else begin
      // oldest entry with matching destination, source too unless any
      foreach (held_msgs[i]) begin
        if (hit < 0 && held_msgs[i].dst == did && (any || held_msgs[i].src == sid))
          hit = i;
      end
      if (hit >= 0) begin
        r.status = ST_TAKEN;
        r.src    = held_msgs[hit].src;
        r.dst    = held_msgs[hit].dst;
        r.body   = held_msgs[hit].body;
        held_msgs.delete(hit);
      end
    end
    r.fill = FILL_W'(held_msgs.size());
    return r;
  endfunction

  // watch both channels at each edge
  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      held_msgs.delete();
      owed_results.delete();
    end else begin
      if (req.valid === 1'b1 && req.ready === 1'b1)
        owed_results.push_back(apply_request(req.req_type, req.source_id, req.dest_id,
                                             req.match_any_source, req.payload));
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result item with nothing expected, status %0d",
                                    rsp.status));
        end else begin
          want = owed_results.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d", want.status,
                                      rsp.status));
          if (rsp.out_source !== want.src)
            report_mismatch($sformatf("out_source expected %0h got %0h", want.src,
                                      rsp.out_source));
          if (rsp.out_dest !== want.dst)
            report_mismatch($sformatf("out_dest expected %0h got %0h", want.dst,
                                      rsp.out_dest));
          if (rsp.out_payload !== want.body)
            report_mismatch($sformatf("out_payload expected %0h got %0h", want.body,
                                      rsp.out_payload));
          if (rsp.fill_level !== want.fill)
            report_mismatch($sformatf("fill_level expected %0d got %0d", want.fill,
                                      rsp.fill_level));
        end
      end
    end
  end

endmodule

>>> sim/tb_matching_message_queue.sv
// tb_matching_message_queue: stimulus, stalls and verdict for the matching message queue
module tb_matching_message_queue import mmq_pkg::*; ();

  localparam int RANDOM_ITEMS = 1075;
  localparam int PHASE_LEN    = 135;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 2 * QUEUE_DEPTH_DEF + 8;

  logic clk;
  logic rst;
  logic no_idle;
  logic hold_results;
  int   fail_count;
  int   pending;
  logic [ID_W-1:0] id_pool [4];

  mmq_req_if req_ch ();
  mmq_rsp_if rsp_ch ();

  matching_message_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  mmq_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard limit on run time
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ids mostly from a small pool so takes find matches
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(3)];
    return ID_W'($urandom_range(255));
  endfunction

  // offer one request item and wait until it is accepted
  task automatic send_req(input logic kind, input logic [ID_W-1:0] sid,
                          input logic [ID_W-1:0] did, input logic any,
                          input logic [PAY_FLD_W-1:0] body);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.req_type         <= kind;
    req_ch.source_id        <= sid;
    req_ch.dest_id          <= did;
    req_ch.match_any_source <= any;
    req_ch.payload          <= body;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // result side: random stalls plus one long hold on request
  initial begin
    int n;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_results) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
  end

  // request side: directed items, then random phases
  initial begin
    logic                 kind;
    logic                 any;
    logic [ID_W-1:0]      sid;
    logic [ID_W-1:0]      did;
    logic [PAY_FLD_W-1:0] body;
    int                   sent;
    int                   phase;
    int                   put_pct;
    no_idle                 = 1'b0;
    hold_results            = 1'b0;
    sent                    = 0;
    phase                   = 0;
    req_ch.valid            <= 1'b0;
    req_ch.req_type         <= REQ_PUT;
    req_ch.source_id        <= '0;
    req_ch.dest_id          <= '0;
    req_ch.match_any_source <= 1'b0;
    req_ch.payload          <= '0;
    rst                     <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // take from an empty store, with and without the match-any flag
    send_req(REQ_TAKE, 8'h00, 8'h00, 1'b0, 32'h0);
    send_req(REQ_TAKE, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);

    // fill the store; extreme ids and payloads, repeated destinations
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
      sid  = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : ID_W'(i * 17);
      did  = (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'h5A;
      body = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF :
             (i == 2) ? 32'hAAAA_AAAA : (i == 3) ? 32'h5555_5555 : 32'($urandom);
      send_req(REQ_PUT, sid, did, i[0], body);
    end

    // put into a full store, flag set and ignored
    send_req(REQ_PUT, 8'h12, 8'h34, 1'b1, 32'hDEAD_BEEF);

    // destination present but source differs
    send_req(REQ_TAKE, 8'h01, 8'h5A, 1'b0, 32'h0);
    // match-any takes an entry from the middle
    send_req(REQ_TAKE, 8'h01, 8'h5A, 1'b1, 32'h0);
    // exact match on the head entries
    send_req(REQ_TAKE, 8'hFF, 8'h00, 1'b0, 32'h0);
    send_req(REQ_TAKE, 8'h00, 8'hFF, 1'b0, 32'h0);
    // oldest of several with the same destination
    send_req(REQ_TAKE, 8'h00, 8'h5A, 1'b1, 32'h0);
    // the tail entry
    send_req(REQ_TAKE, 8'hFF, 8'hFF, 1'b0, 32'h0);
    drain();

    // random phases: vary the put/take mix so the store swings full and empty
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0:       put_pct = 85;
        1:       put_pct = 25;
        2:       put_pct = 60;
        default: put_pct = 50;
      endcase
      no_idle = (phase % 5 == 3);
      foreach (id_pool[k]) id_pool[k] = ID_W'($urandom_range(255));
      if (phase == 1) hold_results = 1'b1;
      for (int j = 0; j < PHASE_LEN && sent < RANDOM_ITEMS; j++) begin
        kind = ($urandom_range(99) < put_pct) ? REQ_PUT : REQ_TAKE;
        any  = 1'($urandom_range(1));
        sid  = pick_id();
        did  = pick_id();
        body = 32'($urandom);
        send_req(kind, sid, did, any, body);
        sent++;
      end
      drain();
      phase++;
    end

    // let any late item show up, then give the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mmq_pkg.sv
rtl/mmq_if.sv
rtl/mmq_store.sv
rtl/mmq_ctrl.sv
rtl/matching_message_queue.sv
sim/mmq_checker.sv
sim/tb_matching_message_queue.sv
